// ----- src/ptc_pkg.sv -----
// ptc_pkg: shared types, constants and helpers for the pressure and
// temperature compensation block; no dependencies
package ptc_pkg;

    localparam int RAW_W   = 20;
    localparam int CFG_W   = 64;
    localparam int Q_DEPTH = 2;

    typedef enum logic [1:0] {
        CFG_TEMP  = 2'd0,
        CFG_PLOW  = 2'd1,
        CFG_PHIGH = 2'd2,
        CFG_P9    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0]        t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic [15:0]        p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } coeff_t;

    typedef struct packed {
        logic [RAW_W-1:0] raw_temperature;
        logic [RAW_W-1:0] raw_pressure;
    } sample_t;

    typedef struct packed {
        logic        start;
        logic        done;
    } div_ctl_t;

    localparam logic [63:0] PRES_OFFSET = 64'd128000;
    localparam logic [63:0] PRES_FULL   = 64'd1048576;
    localparam logic [63:0] PRES_SCALE  = 64'd3125;
    localparam logic [63:0] HALF_RANGE  = 64'h0000_8000_0000_0000;
    // ceil(2^37 / 100): exact quotient for values below 2^31
    localparam logic [63:0] RECIP_100   = 64'd1374389535;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        sx16 = {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sx32(input logic [31:0] v);
        sx32 = {{32{v[31]}}, v};
    endfunction

endpackage

// ----- src/ptc_sample_if.sv -----
// ptc_sample_if: request channel carrying one pair of raw readings
// depends on ptc_pkg
interface ptc_sample_if;
    logic                        valid;
    logic                        ready;
    logic [ptc_pkg::RAW_W-1:0]   raw_temperature;
    logic [ptc_pkg::RAW_W-1:0]   raw_pressure;

    modport source (output valid, output raw_temperature, output raw_pressure,
                    input ready);
    modport sink   (input valid, input raw_temperature, input raw_pressure,
                    output ready);
endinterface

// ----- src/ptc_result_if.sv -----
// ptc_result_if: result channel carrying compensated values
// no dependencies
interface ptc_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic [15:0]        temp_whole_degrees;
    logic               divisor_zero;

    modport source (output valid, output temperature_centi, output pressure_q24_8,
                    output temp_whole_degrees, output divisor_zero, input ready);
    modport sink   (input valid, input temperature_centi, input pressure_q24_8,
                    input temp_whole_degrees, input divisor_zero, output ready);
endinterface

// ----- src/ptc_front.sv -----
// ptc_front: accepts sample requests into a short queue ahead of the sequencer
// depends on ptc_pkg, ptc_sample_if
module ptc_front (
    input  logic         clk,
    input  logic         rst_n,
    ptc_sample_if.sink   samples,
    ptc_sample_if.source queued
);
    import ptc_pkg::*;

    sample_t     slot_reg [Q_DEPTH];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        pop;

    assign samples.ready          = (count_reg != 2'(Q_DEPTH));
    assign push                   = samples.valid && samples.ready;
    assign queued.valid           = (count_reg != 2'd0);
    assign pop                    = queued.valid && queued.ready;
    assign queued.raw_temperature = slot_reg[rd_ptr_reg].raw_temperature;
    assign queued.raw_pressure    = slot_reg[rd_ptr_reg].raw_pressure;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg].raw_temperature <= samples.raw_temperature;
            slot_reg[wr_ptr_reg].raw_pressure    <= samples.raw_pressure;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(Q_DEPTH))
        else $error("queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue count lost a push");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers differ while empty");

endmodule

// ----- src/ptc_divider.sv -----
// ptc_divider: signed 64-bit divider, one quotient bit per cycle,
// truncating toward zero; depends on ptc_pkg
module ptc_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  ptc_pkg::div_ctl_t   ctl_in,
    output ptc_pkg::div_ctl_t   ctl_out,
    input  logic [63:0]         numer,
    input  logic [63:0]         denom,
    output logic [63:0]         quotient
);
    import ptc_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [6:0]  cnt_reg;
    logic        neg_reg;
    logic [63:0] quo_reg;
    logic [63:0] rem_reg;
    logic [63:0] den_reg;
    logic [64:0] trial;
    logic [64:0] diff;
    logic [63:0] mag_n;
    logic [63:0] mag_d;

    assign mag_n = numer[63] ? (64'd0 - numer) : numer;
    assign mag_d = denom[63] ? (64'd0 - denom) : denom;
    assign trial = {rem_reg, quo_reg[63]};
    assign diff  = trial - {1'b0, den_reg};

    assign ctl_out.start = busy_reg;
    assign ctl_out.done  = done_reg;
    assign quotient      = neg_reg ? (64'd0 - quo_reg) : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl_in.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.start)
        begin
            neg_reg <= numer[63] ^ denom[63];
            quo_reg <= mag_n;
            den_reg <= mag_d;
            rem_reg <= 64'd0;
        end
        else if (busy_reg)
        begin
            if (!diff[64])
            begin
                rem_reg <= diff[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[63:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != 7'd0 && cnt_reg <= 7'd64))
        else $error("divider count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without work");

endmodule

// ----- src/ptc_back.sv -----
// ptc_back: sequencer running the compensation on a shared 32x32 multiplier
// and the divider; depends on ptc_pkg, ptc_sample_if, ptc_result_if, ptc_divider
module ptc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  ptc_pkg::coeff_t coeff,
    ptc_sample_if.sink      queued,
    ptc_result_if.source    results
);
    import ptc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_POST = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic [3:0] S_A  = 4'd0;
    localparam logic [3:0] S_B  = 4'd1;
    localparam logic [3:0] S_C  = 4'd2;
    localparam logic [3:0] S_WH = 4'd3;
    localparam logic [3:0] S_XX = 4'd4;
    localparam logic [3:0] S_Y6 = 4'd5;
    localparam logic [3:0] S_Y5 = 4'd6;
    localparam logic [3:0] S_U3 = 4'd7;
    localparam logic [3:0] S_W2 = 4'd8;
    localparam logic [3:0] S_Z1 = 4'd9;
    localparam logic [3:0] S_N  = 4'd10;
    localparam logic [3:0] S_HH = 4'd11;
    localparam logic [3:0] S_C9 = 4'd12;
    localparam logic [3:0] S_C8 = 4'd13;

    logic [2:0]  state_reg, state_next;
    logic [3:0]  step_reg, step_next;
    logic [1:0]  mph_reg, mph_next;
    logic [63:0] ma_reg, ma_next;
    logic [63:0] mb_reg, mb_next;
    logic [63:0] acc_reg, acc_next;
    logic [19:0] rp_reg, rp_next;
    logic [31:0] v1_reg, v1_next;
    logic [31:0] temp_reg, temp_next;
    logic [15:0] whole_reg, whole_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] xx_reg, xx_next;
    logic [63:0] y_reg, y_next;
    logic [63:0] xv_reg, xv_next;
    logic [63:0] xd_reg, xd_next;
    logic [63:0] p_reg, p_next;
    logic [63:0] c9_reg, c9_next;
    logic [31:0] pres_reg, pres_next;
    logic        dz_reg, dz_next;
    logic        ov_reg, ov_next;

    logic [31:0] temp_work_reg;
    logic [15:0] whole_work_reg;
    logic [31:0] pres_work_reg;
    logic        dz_work_reg;

    logic [31:0] pa;
    logic [31:0] pb;
    logic [63:0] prod;
    logic [31:0] a_t;
    logic [31:0] b_t;
    logic [31:0] fine;
    logic [31:0] fine5;
    logic [63:0] sum_p;
    logic [32:0] pdiff;
    div_ctl_t    div_in;
    div_ctl_t    div_out;
    logic [63:0] div_q;
    logic        out_take;

    ptc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (div_in),
        .ctl_out  (div_out),
        .numer    (acc_reg),
        .denom    (xd_reg),
        .quotient (div_q)
    );

    assign queued.ready = (state_reg == ST_IDLE);
    assign out_take     = results.ready || !ov_reg;

    assign results.valid              = ov_reg;
    assign results.temperature_centi  = temp_reg;
    assign results.pressure_q24_8     = pres_reg;
    assign results.temp_whole_degrees = temp_reg[31] ? 16'd0 : whole_reg;
    assign results.divisor_zero       = dz_reg;

    always_comb
    begin
        case (mph_reg)
            2'd0:    begin pa = ma_reg[31:0];  pb = mb_reg[31:0];  end
            2'd1:    begin pa = ma_reg[31:0];  pb = mb_reg[63:32]; end
            default: begin pa = ma_reg[63:32]; pb = mb_reg[31:0];  end
        endcase
        prod = {32'd0, pa} * {32'd0, pb};
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        mph_next   = mph_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        acc_next   = acc_reg;
        rp_next    = rp_reg;
        v1_next    = v1_reg;
        temp_next  = temp_work_reg;
        whole_next = whole_work_reg;
        x_next     = x_reg;
        xx_next    = xx_reg;
        y_next     = y_reg;
        xv_next    = xv_reg;
        xd_next    = xd_reg;
        p_next     = p_reg;
        c9_next    = c9_reg;
        pres_next  = pres_work_reg;
        dz_next    = dz_work_reg;
        ov_next    = ov_reg && !results.ready;
        div_in     = '{start: 1'b0, done: 1'b0};

        a_t   = {15'd0, queued.raw_temperature[19:3]} - {15'd0, coeff.t1, 1'b0};
        b_t   = 32'($signed(acc_reg[31:0]) >>> 12);
        fine  = v1_reg + 32'($signed(acc_reg[31:0]) >>> 14);
        fine5 = fine + {fine[29:0], 2'b00} + 32'd128;
        sum_p = p_reg + c9_reg + 64'($signed(acc_reg) >>> 19);
        pdiff = PRES_FULL[32:0] - {13'd0, rp_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (queued.valid)
                begin
                    rp_next    = queued.raw_pressure;
                    ma_next    = sx32(a_t);
                    mb_next    = sx16(coeff.t2);
                    step_next  = S_A;
                    mph_next   = 2'd0;
                    state_next = ST_MUL;
                    // b needs the raw temperature later, keep it in x for now
                    x_next     = {44'd0, queued.raw_temperature};
                end
            end
            ST_MUL:
            begin
                if (mph_reg == 2'd0)
                    acc_next = prod;
                else
                    acc_next = acc_reg + {prod[31:0], 32'd0};
                if (mph_reg == 2'd2)
                begin
                    mph_next   = 2'd0;
                    state_next = ST_POST;
                end
                else
                    mph_next = mph_reg + 2'd1;
            end
            ST_POST:
            begin
                state_next = ST_MUL;
                case (step_reg)
                    S_A:
                    begin
                        v1_next   = 32'($signed(acc_reg[31:0]) >>> 11);
                        ma_next   = sx32({16'd0, x_reg[19:4]} - {16'd0, coeff.t1});
                        mb_next   = sx32({16'd0, x_reg[19:4]} - {16'd0, coeff.t1});
                        step_next = S_B;
                    end
                    S_B:
                    begin
                        ma_next   = sx32(b_t);
                        mb_next   = sx16(coeff.t3);
                        step_next = S_C;
                    end
                    S_C:
                    begin
                        temp_next = 32'($signed(fine5) >>> 8);
                        x_next    = sx32(fine) - PRES_OFFSET;
                        ma_next   = {32'd0, 32'($signed(fine5) >>> 8)};
                        mb_next   = RECIP_100;
                        step_next = S_WH;
                    end
                    S_WH:
                    begin
                        whole_next = acc_reg[52:37];
                        ma_next    = x_reg;
                        mb_next    = x_reg;
                        step_next  = S_XX;
                    end
                    S_XX:
                    begin
                        xx_next   = acc_reg;
                        ma_next   = acc_reg;
                        mb_next   = sx16(coeff.p6);
                        step_next = S_Y6;
                    end
                    S_Y6:
                    begin
                        y_next    = acc_reg;
                        ma_next   = x_reg;
                        mb_next   = sx16(coeff.p5);
                        step_next = S_Y5;
                    end
                    S_Y5:
                    begin
                        y_next    = y_reg + {acc_reg[46:0], 17'd0}
                                  + {{13{coeff.p4[15]}}, coeff.p4, 35'd0};
                        ma_next   = xx_reg;
                        mb_next   = sx16(coeff.p3);
                        step_next = S_U3;
                    end
                    S_U3:
                    begin
                        xv_next   = 64'($signed(acc_reg) >>> 8);
                        ma_next   = x_reg;
                        mb_next   = sx16(coeff.p2);
                        step_next = S_W2;
                    end
                    S_W2:
                    begin
                        xv_next   = xv_reg + {acc_reg[51:0], 12'd0};
                        ma_next   = HALF_RANGE + xv_reg + {acc_reg[51:0], 12'd0};
                        mb_next   = {48'd0, coeff.p1};
                        step_next = S_Z1;
                    end
                    S_Z1:
                    begin
                        xd_next   = 64'($signed(acc_reg) >>> 33);
                        ma_next   = {pdiff, 31'd0} - y_reg;
                        mb_next   = PRES_SCALE;
                        step_next = S_N;
                    end
                    S_N:
                    begin
                        if (xd_reg == 64'd0)
                        begin
                            dz_next    = 1'b1;
                            pres_next  = 32'd0;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            dz_next      = 1'b0;
                            div_in.start = 1'b1;
                            state_next   = ST_DIV;
                        end
                    end
                    S_HH:
                    begin
                        ma_next   = acc_reg;
                        mb_next   = sx16(coeff.p9);
                        step_next = S_C9;
                    end
                    S_C9:
                    begin
                        c9_next   = 64'($signed(acc_reg) >>> 25);
                        ma_next   = sx16(coeff.p8);
                        mb_next   = p_reg;
                        step_next = S_C8;
                    end
                    S_C8:
                    begin
                        pres_next  = 32'(64'($signed(sum_p) >>> 8)
                                   + {{44{coeff.p7[15]}}, coeff.p7, 4'd0});
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_DIV:
            begin
                if (div_out.done)
                begin
                    p_next     = div_q;
                    ma_next    = 64'($signed(div_q) >>> 13);
                    mb_next    = 64'($signed(div_q) >>> 13);
                    step_next  = S_HH;
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (out_take)
                begin
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= S_A;
            mph_reg   <= 2'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            mph_reg   <= mph_next;
            ov_reg    <= ov_next;
        end
    end

    // result registers only change when the output stage is being loaded
    always_ff @(posedge clk)
    begin
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        acc_reg   <= acc_next;
        rp_reg    <= rp_next;
        v1_reg    <= v1_next;
        x_reg     <= x_next;
        xx_reg    <= xx_next;
        y_reg     <= y_next;
        xv_reg    <= xv_next;
        xd_reg    <= xd_next;
        p_reg     <= p_next;
        c9_reg    <= c9_next;
        if (state_reg == ST_DONE && out_take)
        begin
            temp_reg  <= temp_work_reg;
            whole_reg <= whole_work_reg;
            pres_reg  <= pres_work_reg;
            dz_reg    <= dz_work_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        temp_work_reg  <= temp_next;
        whole_work_reg <= whole_next;
        pres_work_reg  <= pres_next;
        dz_work_reg    <= dz_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (mph_reg != 2'd3))
        else $error("multiplier phase out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        div_out.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside divide state");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !results.ready) |=> (ov_reg && $stable(pres_reg)))
        else $error("pending result disturbed");

endmodule

// ----- src/pressure_temperature_compensation.sv -----
// one request is processed at a time, while the queue ahead holds further
// requests; each is worked through the shared 32x32 multiplier (14 products
// when the divisor is nonzero) and the bit-serial divider, which is skipped
// when the divisor is zero
// reset clears all coefficients to zero and empties the queue and output stage
// depends on ptc_pkg, ptc_sample_if, ptc_result_if, ptc_front, ptc_back
module pressure_temperature_compensation (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  ptc_pkg::cfg_idx_t         cfg_index,
    input  logic [ptc_pkg::CFG_W-1:0] cfg_data,
    ptc_sample_if.sink                samples,
    ptc_result_if.source              results
);
    import ptc_pkg::*;

    logic [47:0] temp_coeffs_reg;
    logic [63:0] plow_reg;
    logic [63:0] phigh_reg;
    logic [15:0] p9_reg;
    coeff_t      coeff;

    ptc_sample_if queued ();

    assign coeff.t1 = temp_coeffs_reg[15:0];
    assign coeff.t2 = temp_coeffs_reg[31:16];
    assign coeff.t3 = temp_coeffs_reg[47:32];
    assign coeff.p1 = plow_reg[15:0];
    assign coeff.p2 = plow_reg[31:16];
    assign coeff.p3 = plow_reg[47:32];
    assign coeff.p4 = plow_reg[63:48];
    assign coeff.p5 = phigh_reg[15:0];
    assign coeff.p6 = phigh_reg[31:16];
    assign coeff.p7 = phigh_reg[47:32];
    assign coeff.p8 = phigh_reg[63:48];
    assign coeff.p9 = p9_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg <= 48'd0;
            plow_reg        <= 64'd0;
            phigh_reg       <= 64'd0;
            p9_reg          <= 16'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TEMP:  temp_coeffs_reg <= cfg_data[47:0];
                CFG_PLOW:  plow_reg        <= cfg_data;
                CFG_PHIGH: phigh_reg       <= cfg_data;
                CFG_P9:    p9_reg          <= cfg_data[15:0];
                default:   p9_reg          <= p9_reg;
            endcase
        end
    end

    ptc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .queued  (queued.source)
    );

    ptc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .coeff   (coeff),
        .queued  (queued.sink),
        .results (results)
    );

endmodule

// ----- sim/tb.sv -----
// tb: self-checking testbench for pressure_temperature_compensation
// drives raw reading pairs and coefficient sets, predicts each result in-house
// depends on ptc_pkg, ptc_sample_if, ptc_result_if and the block itself
`timescale 1ns / 100ps

module tb;
    import ptc_pkg::*;

    localparam int N_RANDOM   = 1000;
    localparam int QUIET_FROM = 900;
    localparam int SETTLE     = 200;
    localparam int LONG_HOLD  = 400;
    localparam int WD_LIMIT   = 5000;

    typedef struct {
        logic signed [31:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
        logic [15:0]        temp_whole_degrees;
        logic               divisor_zero;
    } reading_t;

    typedef struct {
        logic [63:0] temp;
        logic [63:0] plow;
        logic [63:0] phigh;
        logic [63:0] p9;
    } coeff_set_t;

    typedef struct {
        int          set_no;
        logic [19:0] raw_t;
        logic [19:0] raw_p;
        bit          typed;
        reading_t    want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_idx_t cfg_index;
    logic [CFG_W-1:0] cfg_data;

    ptc_sample_if samples_ch();
    ptc_result_if results_ch();

    pressure_temperature_compensation u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples_ch),
        .results   (results_ch)
    );

    // mirrored coefficient registers
    logic [47:0] coef_temp;
    logic [63:0] coef_plow;
    logic [63:0] coef_phigh;
    logic [15:0] coef_p9;

    reading_t expected_readings[$];
    int       n_errors;
    bit       quiet;
    bit       want_hold;
    bit       hold_done;
    int       hold_left;
    int       gap_left;
    int       idle_cycles;

    coeff_set_t coeff_sets[5];
    stim_row_t  directed[$];

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic logic [31:0] asr32(input logic [31:0] v, input int n);
        asr32 = $signed(v) >>> n;
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] v, input int n);
        asr64 = $signed(v) >>> n;
    endfunction

    function automatic logic [63:0] ext16(input logic [15:0] v);
        ext16 = {{48{v[15]}}, v};
    endfunction

    function automatic reading_t compensate(input logic [19:0] rt, input logic [19:0] rp);
        logic [31:0] t1, t2, t3, a, b, v1, v2, fine, prod, tc;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] x, y, p, num, ma, mb, q, h, c9, c8;
        reading_t r;
        t1 = {16'd0, coef_temp[15:0]};
        t2 = {{16{coef_temp[31]}}, coef_temp[31:16]};
        t3 = {{16{coef_temp[47]}}, coef_temp[47:32]};
        p1 = {48'd0, coef_plow[15:0]};
        p2 = ext16(coef_plow[31:16]);
        p3 = ext16(coef_plow[47:32]);
        p4 = ext16(coef_plow[63:48]);
        p5 = ext16(coef_phigh[15:0]);
        p6 = ext16(coef_phigh[31:16]);
        p7 = ext16(coef_phigh[47:32]);
        p8 = ext16(coef_phigh[63:48]);
        p9 = ext16(coef_p9);

        a = ({12'd0, rt} >> 3) - (t1 << 1);
        prod = a * t2;
        v1 = asr32(prod, 11);
        b = ({12'd0, rt} >> 4) - t1;
        prod = b * b;
        prod = asr32(prod, 12) * t3;
        v2 = asr32(prod, 14);
        fine = v1 + v2;
        prod = fine * 32'd5 + 32'd128;
        tc = asr32(prod, 8);

        x = {{32{fine[31]}}, fine} - 64'd128000;
        y = x * x * p6;
        y = y + ((x * p5) << 17);
        y = y + (p4 << 35);
        x = asr64(x * x * p3, 8) + ((x * p2) << 12);
        x = asr64(((64'd1 << 47) + x) * p1, 33);

        r.temperature_centi = tc;
        r.temp_whole_degrees = tc[31] ? 16'd0 : 16'((tc / 32'd100) & 32'hFFFF);
        if (x == 64'd0)
        begin
            r.divisor_zero = 1'b1;
            r.pressure_q24_8 = 32'd0;
        end
        else
        begin
            p = 64'd1048576 - {44'd0, rp};
            num = ((p << 31) - y) * 64'd3125;
            ma = num[63] ? 64'd0 - num : num;
            mb = x[63] ? 64'd0 - x : x;
            q = ma / mb;
            p = (num[63] != x[63]) ? 64'd0 - q : q;
            h = asr64(p, 13);
            c9 = asr64(p9 * h * h, 25);
            c8 = asr64(p8 * p, 19);
            q = asr64(p + c9 + c8, 8) + (p7 << 4);
            r.divisor_zero = 1'b0;
            r.pressure_q24_8 = q[31:0];
        end
        return r;
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [63:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        case (idx)
            CFG_TEMP:  coef_temp = d[47:0];
            CFG_PLOW:  coef_plow = d;
            CFG_PHIGH: coef_phigh = d;
            CFG_P9:    coef_p9 = d[15:0];
            default:   coef_p9 = coef_p9;
        endcase
    endtask

    task automatic load_coeffs(input coeff_set_t s);
        write_reg(CFG_TEMP, s.temp);
        write_reg(CFG_PLOW, s.plow);
        write_reg(CFG_PHIGH, s.phigh);
        write_reg(CFG_P9, s.p9);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // wait for every outstanding result, then let the pipeline settle
    task automatic drain;
        samples_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_request(input logic [19:0] rt, input logic [19:0] rp,
                                input bit typed, input reading_t want);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 13);
            samples_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_ch.valid <= 1'b1;
        samples_ch.raw_temperature <= rt;
        samples_ch.raw_pressure <= rp;
        do
            @(posedge clk);
        while (!samples_ch.ready);
        expected_readings.push_back(typed ? want : compensate(rt, rp));
    endtask

    function automatic logic [19:0] pick_raw;
        case ($urandom_range(0, 9))
            0:       pick_raw = 20'h00000;
            1:       pick_raw = 20'hFFFFF;
            2, 3, 4: pick_raw = 20'($urandom_range(300000, 600000));
            default: pick_raw = 20'($urandom);
        endcase
    endfunction

    function automatic coeff_set_t random_coeffs;
        coeff_set_t s;
        if ($urandom_range(0, 2) != 0)
        begin
            // realistic sensor trim with random spread
            s.temp  = {16'(-1000 + $urandom_range(0, 2000)),
                       16'(26000 + $urandom_range(0, 1000)),
                       16'(27000 + $urandom_range(0, 1000))};
            s.plow  = {16'(2000 + $urandom_range(0, 1500)),
                       16'(3000 + $urandom_range(0, 200)),
                       16'(-10800 + $urandom_range(0, 300)),
                       16'(36000 + $urandom_range(0, 1000))};
            s.phigh = {16'(-14700 + $urandom_range(0, 300)),
                       16'(15000 + $urandom_range(0, 1000)),
                       16'(-7 + $urandom_range(0, 6)),
                       16'($urandom_range(0, 300))};
            s.p9    = 64'($urandom_range(4000, 8000));
        end
        else
        begin
            s.temp  = {$urandom, $urandom};
            s.plow  = {$urandom, $urandom};
            s.phigh = {$urandom, $urandom};
            s.p9    = {$urandom, $urandom};
        end
        return s;
    endfunction

    function automatic stim_row_t row(input int set_no, input logic [19:0] rt,
                                      input logic [19:0] rp, input bit typed);
        stim_row_t r;
        r.set_no = set_no;
        r.raw_t = rt;
        r.raw_p = rp;
        r.typed = typed;
        // with all coefficients zero: temperature 0, divisor zero
        r.want.temperature_centi = 32'sd0;
        r.want.pressure_q24_8 = 32'd0;
        r.want.temp_whole_degrees = 16'd0;
        r.want.divisor_zero = 1'b1;
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            if (expected_readings.size() == 0)
            begin
                $error("result with no request outstanding");
                n_errors++;
            end
            else
            begin
                reading_t e;
                e = expected_readings.pop_front();
                if (results_ch.temperature_centi !== e.temperature_centi)
                begin
                    $error("temperature_centi: expected %0d, got %0d",
                           e.temperature_centi, results_ch.temperature_centi);
                    n_errors++;
                end
                if (results_ch.pressure_q24_8 !== e.pressure_q24_8)
                begin
                    $error("pressure_q24_8: expected %0d, got %0d",
                           e.pressure_q24_8, results_ch.pressure_q24_8);
                    n_errors++;
                end
                if (results_ch.temp_whole_degrees !== e.temp_whole_degrees)
                begin
                    $error("temp_whole_degrees: expected %0d, got %0d",
                           e.temp_whole_degrees, results_ch.temp_whole_degrees);
                    n_errors++;
                end
                if (results_ch.divisor_zero !== e.divisor_zero)
                begin
                    $error("divisor_zero: expected %0d, got %0d",
                           e.divisor_zero, results_ch.divisor_zero);
                    n_errors++;
                end
            end
        end
    end

    // result-side back-pressure
    always @(posedge clk)
    begin
        if (want_hold && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            results_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            results_ch.ready <= 1'b0;
        end
        else if (gap_left > 0)
        begin
            gap_left <= gap_left - 1;
            results_ch.ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            gap_left <= $urandom_range(0, 12);
            results_ch.ready <= 1'b0;
        end
        else
            results_ch.ready <= 1'b1;
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((samples_ch.valid && samples_ch.ready) || (results_ch.valid && results_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WD_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int cur_set;
        reading_t none;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_TEMP;
        cfg_data = '0;
        samples_ch.valid = 1'b0;
        samples_ch.raw_temperature = '0;
        samples_ch.raw_pressure = '0;
        results_ch.ready = 1'b0;
        coef_temp = '0;
        coef_plow = '0;
        coef_phigh = '0;
        coef_p9 = '0;
        n_errors = 0;
        quiet = 1'b0;
        want_hold = 1'b0;
        hold_done = 1'b0;
        hold_left = 0;
        gap_left = 0;
        idle_cycles = 0;
        none = '{default: '0};

        // set 0: reset state; 1: typical trim; 2: all ones; 3: sign extremes;
        // 4: typical trim with p1 zero, so the divisor is zero
        coeff_sets[0] = '{64'd0, 64'd0, 64'd0, 64'd0};
        coeff_sets[1] = '{{16'(-1000), 16'd26435, 16'd27504},
                          {16'd2855, 16'd3024, 16'(-10685), 16'd36477},
                          {16'(-14600), 16'd15500, 16'(-7), 16'd140}, 64'd6000};
        coeff_sets[2] = '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                          64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
        coeff_sets[3] = '{64'h0000_8000_8000_FFFF, 64'h8000_8000_8000_FFFF,
                          64'h8000_8000_8000_8000, 64'h0000_0000_0000_8000};
        coeff_sets[4] = coeff_sets[1];
        coeff_sets[4].plow[15:0] = 16'd0;

        directed.push_back(row(0, 20'h00000, 20'h00000, 1));
        directed.push_back(row(0, 20'hFFFFF, 20'hFFFFF, 1));
        directed.push_back(row(0, 20'h80000, 20'h00000, 1));
        directed.push_back(row(0, 20'h00000, 20'h80000, 1));
        directed.push_back(row(1, 20'd519888, 20'd415148, 0));
        directed.push_back(row(1, 20'h00000, 20'h00000, 0));
        directed.push_back(row(1, 20'hFFFFF, 20'hFFFFF, 0));
        directed.push_back(row(1, 20'h00000, 20'hFFFFF, 0));
        directed.push_back(row(1, 20'hFFFFF, 20'h00000, 0));
        directed.push_back(row(1, 20'd400000, 20'd300000, 0));
        directed.push_back(row(2, 20'h00000, 20'h00000, 0));
        directed.push_back(row(2, 20'hFFFFF, 20'hFFFFF, 0));
        directed.push_back(row(2, 20'h55555, 20'hAAAAA, 0));
        directed.push_back(row(3, 20'h00000, 20'h00000, 0));
        directed.push_back(row(3, 20'hFFFFF, 20'hFFFFF, 0));
        directed.push_back(row(3, 20'hAAAAA, 20'h55555, 0));
        directed.push_back(row(4, 20'd519888, 20'd415148, 0));
        directed.push_back(row(4, 20'hFFFFF, 20'h00000, 0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur_set = 0;
        foreach (directed[i])
        begin
            if (directed[i].set_no != cur_set)
            begin
                drain();
                cur_set = directed[i].set_no;
                load_coeffs(coeff_sets[cur_set]);
            end
            send_request(directed[i].raw_t, directed[i].raw_p, directed[i].typed,
                         directed[i].want);
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n % 100 == 0)
            begin
                drain();
                load_coeffs(n == 0 ? coeff_sets[0] : random_coeffs());
            end
            if (n == 250)
                want_hold = 1'b1;
            if (n == 550)
            begin
                samples_ch.valid <= 1'b0;
                @(posedge clk);
                while (expected_readings.size() != 0)
                    @(posedge clk);
            end
            if (n == QUIET_FROM)
                quiet = 1'b1;
            send_request(pick_raw(), pick_raw(), 0, none);
        end

        samples_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
